// ----- hw/rtl/frame_interval_drop_tracker_core_assert.svh -----
// ----------------------------------------------------------------------------
// Frame interval drop tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef FRAME_INTERVAL_DROP_TRACKER_CORE_ASSERT_SVH
`define FRAME_INTERVAL_DROP_TRACKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame interval drop tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FIDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame interval drop tracker assertion failed");

`endif

// ----- hw/rtl/fidt_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame interval drop tracker package
// Widths, request codes, limits and controller/datapath bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fidt_pkg;

  localparam int STAMP_W = 64;
  localparam int COUNT_W = 8;
  localparam int REQ_W   = 2;

  localparam logic [COUNT_W-1:0] LEARN_INTERVALS = COUNT_W'(10);
  localparam logic [COUNT_W-1:0] MISS_LIMIT      = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_RESET = 2'd2
  } req_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic cmp;
    logic upd;
    logic div_start;
    logic div_apply;
    logic publish;
  } fidt_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } fidt_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fidt_channels.sv -----
// ----------------------------------------------------------------------------
// Frame interval drop tracker channels
// Valid/ready interfaces for the request items and the result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fidt_in_if import fidt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [STAMP_W-1:0] stamp;
  logic                      stamp_present;
  logic                      skip_mode;

  modport source (output valid, req_type, stamp, stamp_present, skip_mode,
                  input ready);
  modport sink (input valid, req_type, stamp, stamp_present, skip_mode,
                output ready);
endinterface

interface fidt_out_if import fidt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      estimate_valid;
  logic signed [STAMP_W-1:0] interval_estimate;
  logic                      frame_dropped;

  modport source (output valid, estimate_valid, interval_estimate, frame_dropped,
                  input ready);
  modport sink (input valid, estimate_valid, interval_estimate, frame_dropped,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fidt_divider.sv -----
// ----------------------------------------------------------------------------
// Frame interval drop tracker divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fidt_divider import fidt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [STAMP_W-1:0] dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic [STAMP_W-1:0] quotient,
  output logic               done
);

  localparam int STEP_W = $clog2(STAMP_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STAMP_W - 1);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [STAMP_W-1:0] quo;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] den;
  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [COUNT_W:0]   diff;

  assign trial = {rem, quo[STAMP_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      den  <= divisor;
      step <= '0;
    end else if (busy) begin
      quo  <= {quo[STAMP_W-2:0], fits};
      rem  <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      step <= step + STEP_W'(1);
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- hw/rtl/fidt_datapath.sv -----
// ----------------------------------------------------------------------------
// Frame interval drop tracker datapath
// Tracker state, interval arithmetic, learning divide and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frame_interval_drop_tracker_core_assert.svh"

module fidt_datapath import fidt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [STAMP_W-1:0] stamp,
  input  logic                      stamp_present,
  input  logic                      skip_mode,
  output logic                      estimate_valid,
  output logic signed [STAMP_W-1:0] interval_estimate,
  output logic                      frame_dropped,
  input  fidt_cmd_t                 cmd,
  output fidt_stat_t                stat
);

  localparam int DEV_W  = STAMP_W + 2;
  localparam int WIDE_W = STAMP_W + 4;

  logic [REQ_W-1:0]          req_r;
  logic signed [STAMP_W-1:0] stamp_r;
  logic                      pres_r;
  logic                      skip_r;

  logic signed [STAMP_W-1:0] last_stamp;
  logic                      last_pres;
  logic                      locked;
  logic signed [STAMP_W-1:0] accum;
  logic [COUNT_W-1:0]        count;

  logic signed [DEV_W-1:0]   dev_r;
  logic signed [WIDE_W-1:0]  rhs_r;
  logic [WIDE_W-1:0]         five_r;
  logic                      drop_r;
  logic                      div_neg;

  logic signed [DEV_W-1:0]   s_d, l_d, e_d;
  logic signed [WIDE_W-1:0]  s_w, l_w, e_w;
  logic [DEV_W-1:0]          abs_dev;
  logic                      both_present;
  logic                      deviating;
  logic [COUNT_W-1:0]        count_inc;
  logic [STAMP_W-1:0]        accum_mag;
  logic [STAMP_W-1:0]        quot;
  logic [STAMP_W-1:0]        quot_s;
  logic                      div_done;

  assign s_d = {{2{stamp_r[STAMP_W-1]}}, stamp_r};
  assign l_d = {{2{last_stamp[STAMP_W-1]}}, last_stamp};
  assign e_d = {{2{accum[STAMP_W-1]}}, accum};
  assign s_w = {{4{stamp_r[STAMP_W-1]}}, stamp_r};
  assign l_w = {{4{last_stamp[STAMP_W-1]}}, last_stamp};
  assign e_w = {{4{accum[STAMP_W-1]}}, accum};

  assign abs_dev      = dev_r[DEV_W-1] ? DEV_W'(-dev_r) : DEV_W'(dev_r);
  assign both_present = pres_r && last_pres;
  assign deviating    = !both_present ||
                        ($signed({1'b0, five_r}) > $signed({e_w[WIDE_W-1], e_w}));
  assign count_inc    = (count == COUNT_MAX) ? count : count + COUNT_W'(1);
  assign accum_mag    = accum[STAMP_W-1] ? STAMP_W'(-accum) : STAMP_W'(accum);
  assign quot_s       = div_neg ? STAMP_W'(-quot) : quot;

  fidt_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (accum_mag),
    .divisor  (count),
    .quotient (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      stamp_r <= stamp;
      pres_r  <= stamp_present;
      skip_r  <= skip_mode;
    end
    if (cmd.calc) begin
      dev_r <= s_d - l_d - e_d;
      rhs_r <= (l_w <<< 1) + (e_w <<< 1) + e_w;
    end
    if (cmd.cmp) begin
      five_r <= {abs_dev, 2'b00} + {2'b00, abs_dev};
      drop_r <= (req_r == REQ_FRAME) && skip_r && locked && both_present &&
                ((s_w <<< 1) > rhs_r);
    end
    if (cmd.div_start) begin
      div_neg <= accum[STAMP_W-1];
    end
    if (cmd.publish) begin
      estimate_valid    <= locked;
      interval_estimate <= accum;
      frame_dropped     <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp <= '0;
      last_pres  <= 1'b0;
      locked     <= 1'b0;
      accum      <= '0;
      count      <= '0;
    end else if (cmd.upd) begin
      case (req_r)
        REQ_FRAME: begin
          if (!locked) begin
            if (both_present) begin
              accum <= accum + stamp_r - last_stamp;
              count <= count_inc;
            end
          end else if (!skip_r) begin
            if (deviating) begin
              if (count_inc > MISS_LIMIT) begin
                locked <= 1'b0;
                accum  <= '0;
                count  <= '0;
              end else begin
                count <= count_inc;
              end
            end else begin
              count <= '0;
            end
          end
          last_stamp <= stamp_r;
          last_pres  <= pres_r;
        end
        REQ_FLUSH: begin
          last_stamp <= '0;
          last_pres  <= 1'b0;
          if (!locked) begin
            accum <= '0;
            count <= '0;
          end
        end
        REQ_RESET: begin
          last_stamp <= '0;
          last_pres  <= 1'b0;
          locked     <= 1'b0;
          accum      <= '0;
          count      <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.div_apply) begin
      accum <= quot_s;
      if (quot_s != '0 && !quot_s[STAMP_W-1]) begin
        locked <= 1'b1;
        count  <= '0;
      end
    end
  end

  assign stat.need_div = (req_r == REQ_FRAME) && !locked && (count > LEARN_INTERVALS);
  assign stat.div_done = div_done;

  `FIDT_ASSERT_IMP(a_locked_positive, locked, !accum[STAMP_W-1] && accum != '0)
  `FIDT_ASSERT_IMP(a_div_count_learned, cmd.div_start, count > LEARN_INTERVALS)

endmodule

`default_nettype wire

// ----- hw/rtl/fidt_controller.sv -----
// ----------------------------------------------------------------------------
// Frame interval drop tracker controller
// Sequences one item through calc, compare, update, optional divide and publish steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frame_interval_drop_tracker_core_assert.svh"

module fidt_controller import fidt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output fidt_cmd_t  cmd,
  input  fidt_stat_t stat
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CALC   = 8'b0000_0010,
    S_CMP    = 8'b0000_0100,
    S_UPD    = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_DIVW   = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_PUB    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end else begin
          state_next = S_PUB;
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_apply = 1'b1;
        state_next    = S_PUB;
      end
      S_PUB: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FIDT_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_CALC)
  `FIDT_ASSERT_NEXT(a_publish_shows, cmd.publish, out_valid && state == S_IDLE)
  `FIDT_ASSERT_IMP(a_done_while_waiting, stat.div_done, state == S_DIVW)

endmodule

`default_nettype wire

// ----- hw/rtl/frame_interval_drop_tracker_core.sv -----
// An accepted item passes through the calc, compare, update and decide states; when
// the learning average is taken, the 64-step restoring divider runs in the wait
// state and the finish state applies it; then publish. Items are accepted only in idle.
// The output register holds one result, so an item may be accepted while it waits.
// Reset (synchronous, rst high) clears the tracker to learning with zero stamp,
// sum and count, and drops any pending result.
// ----------------------------------------------------------------------------
// Frame interval drop tracker core
// Learns the frame interval from presentation stamps and flags dropped frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_interval_drop_tracker_core import fidt_pkg::*; (
  input logic        clk,
  input logic        rst,
  fidt_in_if.sink    frames,
  fidt_out_if.source results
);

  fidt_cmd_t  cmd;
  fidt_stat_t stat;

  fidt_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frames.valid),
    .in_ready  (frames.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fidt_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .req_type          (frames.req_type),
    .stamp             (frames.stamp),
    .stamp_present     (frames.stamp_present),
    .skip_mode         (frames.skip_mode),
    .estimate_valid    (results.estimate_valid),
    .interval_estimate (results.interval_estimate),
    .frame_dropped     (results.frame_dropped),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

`default_nettype wire
